@@ src/jed_pkg.sv @@
// Shared types, codes and reset values for the joystick event decoder.
package jed_pkg;

  // Event codes carried on the action field.
  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_CLICK = 3'd1,
    ACT_LONG  = 3'd2,
    ACT_RIGHT = 3'd3,
    ACT_LEFT  = 3'd4,
    ACT_UP    = 3'd5,
    ACT_DOWN  = 3'd6
  } jed_action_t;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_READ_INTERVAL = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_HIGH_THRESH   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_LOW_THRESH    = 2'd3;

  localparam int unsigned TimeW   = 16;
  localparam int unsigned SampleW = 12;
  localparam int unsigned CfgDataW = 16;

  // Reset values of the configuration registers.
  localparam logic [TimeW-1:0]   READ_INTERVAL_RST = 16'd50;
  localparam logic [TimeW-1:0]   LONG_PRESS_RST    = 16'd1000;
  localparam logic [SampleW-1:0] HIGH_THRESH_RST   = 12'd3500;
  localparam logic [SampleW-1:0] LOW_THRESH_RST    = 12'd500;

  // Configuration as seen by the decode logic.
  typedef struct packed {
    logic [TimeW-1:0]   read_interval_ms;
    logic [TimeW-1:0]   long_press_ms;
    logic [SampleW-1:0] high_threshold;
    logic [SampleW-1:0] low_threshold;
  } jed_cfg_t;

  // Decoder state carried from one tick to the next.
  typedef struct packed {
    logic [TimeW-1:0] since_read;
    logic [TimeW-1:0] hold_elapsed;
    logic             button_held;
    logic             direction_latched;
  } jed_state_t;

endpackage

@@ src/jed_step.sv @@
// Next-state and event logic for one millisecond tick of the decoder.
module jed_step
  import jed_pkg::*;
(
  input  jed_cfg_t          cfg,
  input  jed_state_t        state,
  input  logic              button_level,
  input  logic [SampleW-1:0] x_sample,
  input  logic [SampleW-1:0] y_sample,
  output jed_state_t        state_next,
  output jed_action_t       action,
  output logic              read_done
);

  logic [TimeW-1:0] since_inc;
  logic [TimeW-1:0] hold_inc;
  logic             do_read;
  logic             pressed;
  logic [TimeW-1:0] hold_press;
  logic             held_mid;
  jed_action_t      btn_action;
  logic             y_high, y_low, x_high, x_low, centred;

  // Saturating millisecond counters.
  assign since_inc = (&state.since_read) ? state.since_read : state.since_read + 1'b1;
  assign hold_inc  = (&state.hold_elapsed) ? state.hold_elapsed : state.hold_elapsed + 1'b1;

  assign do_read = since_inc > cfg.read_interval_ms;
  assign pressed = ~button_level;

  // A new press restarts the hold timer.
  assign hold_press = state.button_held ? hold_inc : '0;

  // Button handling: long click on a long hold, click on release.
  always_comb begin
    btn_action = ACT_NONE;
    held_mid   = state.button_held;
    if (pressed) begin
      if (hold_press > cfg.long_press_ms) begin
        btn_action = ACT_LONG;
        held_mid   = 1'b0;
      end else begin
        held_mid = 1'b1;
      end
    end else begin
      if (state.button_held) begin
        btn_action = ACT_CLICK;
      end
      held_mid = 1'b0;
    end
  end

  // Axis compares against the band.
  assign y_high  = y_sample > cfg.high_threshold;
  assign y_low   = y_sample < cfg.low_threshold;
  assign x_high  = x_sample > cfg.high_threshold;
  assign x_low   = x_sample < cfg.low_threshold;
  assign centred = (x_sample < cfg.high_threshold) && (x_sample > cfg.low_threshold) &&
                   (y_sample < cfg.high_threshold) && (y_sample > cfg.low_threshold);

  // Combine button and direction decisions; a direction event wins.
  always_comb begin
    state_next.since_read        = since_inc;
    state_next.hold_elapsed      = hold_inc;
    state_next.button_held       = state.button_held;
    state_next.direction_latched = state.direction_latched;
    action                       = ACT_NONE;
    read_done                    = 1'b0;
    if (do_read) begin
      read_done              = 1'b1;
      state_next.since_read  = '0;
      state_next.button_held = held_mid;
      action                 = btn_action;
      if (pressed) begin
        state_next.hold_elapsed = hold_press;
      end
      if (!held_mid) begin
        if (!state.direction_latched && y_high) begin
          state_next.direction_latched = 1'b1;
          action                       = ACT_RIGHT;
        end else if (!state.direction_latched && y_low) begin
          state_next.direction_latched = 1'b1;
          action                       = ACT_LEFT;
        end else if (!state.direction_latched && x_high) begin
          state_next.direction_latched = 1'b1;
          action                       = ACT_UP;
        end else if (!state.direction_latched && x_low) begin
          state_next.direction_latched = 1'b1;
          action                       = ACT_DOWN;
        end else if (centred) begin
          state_next.direction_latched = 1'b0;
        end
      end
    end
  end

endmodule

@@ src/joystick_event_decoder_top.sv @@
// Top level of the joystick event decoder: input register, decode, result register.
//
// Each input transaction is one millisecond tick and yields exactly one result
// transaction carrying an action code and a read flag. A tick waits in the input
// register and then moves to the result register, where its result is offered; a
// stall on the result side holds it back. The block takes a new tick in every
// cycle while the result side is not stalled. The decoder state is updated as a tick
// moves from the input register to the result register. Configuration writes
// take effect at once and are meant to be issued while no tick is in flight.
module joystick_event_decoder_top
  import jed_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                button_level,
  input  logic [SampleW-1:0]  x_sample,
  input  logic [SampleW-1:0]  y_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          action,
  output logic                read_done,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  jed_cfg_t     cfg;
  jed_state_t   state;
  jed_state_t   state_next;
  logic         in_q_valid;
  logic         in_q_button;
  logic [SampleW-1:0] in_q_x;
  logic [SampleW-1:0] in_q_y;
  logic         advance;
  jed_action_t  step_action;
  logic         step_read;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.read_interval_ms <= READ_INTERVAL_RST;
      cfg.long_press_ms    <= LONG_PRESS_RST;
      cfg.high_threshold   <= HIGH_THRESH_RST;
      cfg.low_threshold    <= LOW_THRESH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_READ_INTERVAL: cfg.read_interval_ms <= cfg_data;
        REG_LONG_PRESS:    cfg.long_press_ms    <= cfg_data;
        REG_HIGH_THRESH:   cfg.high_threshold   <= cfg_data[SampleW-1:0];
        REG_LOW_THRESH:    cfg.low_threshold    <= cfg_data[SampleW-1:0];
        default: ;
      endcase
    end
  end

  // The input register moves on when the result register is free or being emptied.
  assign advance  = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_q_button <= button_level;
      in_q_x      <= x_sample;
      in_q_y      <= y_sample;
    end
  end

  // Decode of the registered tick.
  jed_step u_step (
    .cfg          (cfg),
    .state        (state),
    .button_level (in_q_button),
    .x_sample     (in_q_x),
    .y_sample     (in_q_y),
    .state_next   (state_next),
    .action       (step_action),
    .read_done    (step_read)
  );

  // Decoder state, updated once per tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      action    <= step_action;
      read_done <= step_read;
    end
  end

  // An event is only ever reported by a tick that performed a read.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (action != ACT_NONE) |-> read_done)
    else $error("event reported without a read");

  // A tick that reads leaves the interval counter cleared.
  assert property (@(posedge clk) disable iff (rst)
    advance && step_read |=> (state.since_read == '0))
    else $error("interval counter not cleared after a read");

  // The input side only stalls while a tick waits in the input register.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_q_valid && out_valid && out_stall)
    else $error("input stalled without a reason");

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the joystick event decoder: stimulus, prediction and result checks.
`timescale 1ns / 100ps

module tb
  import jed_pkg::*;
();

  // Kinds of axis sample used to build gestures.
  typedef enum int {
    AX_CENTRE,
    AX_HIGH,
    AX_LOW,
    AX_AT_HIGH,
    AX_AT_LOW,
    AX_ANY
  } axis_kind_t;

  // One predicted result transaction.
  typedef struct {
    jed_action_t act;
    logic        rd;
  } tick_event_t;

  localparam logic [SampleW-1:0] MID  = 12'd2048;
  localparam logic [SampleW-1:0] FULL = 12'd4095;
  localparam logic [SampleW-1:0] ZERO = 12'd0;
  localparam logic [TimeW-1:0]   TMAX = 16'hFFFF;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                button_level = 1'b1;
  logic [SampleW-1:0]  x_sample = MID;
  logic [SampleW-1:0]  y_sample = MID;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [2:0]          action;
  logic                read_done;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = REG_READ_INTERVAL;
  logic [CfgDataW-1:0] cfg_data = '0;

  // Predictor copy of the configuration and of the decoder state.
  logic [TimeW-1:0]   cfg_read_interval = READ_INTERVAL_RST;
  logic [TimeW-1:0]   cfg_long_press = LONG_PRESS_RST;
  logic [SampleW-1:0] cfg_high = HIGH_THRESH_RST;
  logic [SampleW-1:0] cfg_low = LOW_THRESH_RST;
  logic [TimeW-1:0]   ms_since_read = '0;
  logic [TimeW-1:0]   hold_ms = '0;
  logic               press_tracked = 1'b0;
  logic               dir_latched = 1'b0;

  tick_event_t pending_events[$];
  int          mismatches = 0;
  bit          gaps_enabled = 1'b1;
  int          rx_hold_cycles = 0;

  joystick_event_decoder_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .button_level (button_level),
    .x_sample     (x_sample),
    .y_sample     (y_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .action       (action),
    .read_done    (read_done),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Clock with a 20 ns period.
  initial begin
    forever #10 clk = ~clk;
  end

  // Works out the result of one tick and advances the predicted state.
  function automatic tick_event_t decode_tick(input logic btn, input logic [SampleW-1:0] x,
                                              input logic [SampleW-1:0] y);
    tick_event_t ev;
    ev.act = ACT_NONE;
    ev.rd  = 1'b0;
    if (ms_since_read != TMAX) ms_since_read = ms_since_read + 1'b1;
    if (hold_ms != TMAX) hold_ms = hold_ms + 1'b1;
    if (ms_since_read > cfg_read_interval) begin
      ev.rd = 1'b1;
      if (!btn) begin
        if (!press_tracked) hold_ms = '0;
        press_tracked = 1'b1;
        if (hold_ms > cfg_long_press) begin
          ev.act = ACT_LONG;
          press_tracked = 1'b0;
        end
      end else begin
        if (press_tracked) ev.act = ACT_CLICK;
        press_tracked = 1'b0;
      end
      // Direction is only looked at while no press is being tracked.
      if (!press_tracked) begin
        if (!dir_latched && y > cfg_high) begin
          dir_latched = 1'b1;
          ev.act = ACT_RIGHT;
        end else if (!dir_latched && y < cfg_low) begin
          dir_latched = 1'b1;
          ev.act = ACT_LEFT;
        end else if (!dir_latched && x > cfg_high) begin
          dir_latched = 1'b1;
          ev.act = ACT_UP;
        end else if (!dir_latched && x < cfg_low) begin
          dir_latched = 1'b1;
          ev.act = ACT_DOWN;
        end else if (x < cfg_high && x > cfg_low && y < cfg_high && y > cfg_low) begin
          dir_latched = 1'b0;
        end
      end
      ms_since_read = '0;
    end
    return ev;
  endfunction

  // Gap length in cycles: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic axis_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return AX_CENTRE;
    if (r < 65) return AX_HIGH;
    if (r < 80) return AX_LOW;
    if (r < 85) return AX_AT_HIGH;
    if (r < 90) return AX_AT_LOW;
    return AX_ANY;
  endfunction

  // Draws a sample of the given kind against the current thresholds.
  function automatic logic [SampleW-1:0] axis_value(input axis_kind_t k);
    int hi;
    int lo;
    hi = int'(cfg_high);
    lo = int'(cfg_low);
    case (k)
      AX_CENTRE: begin
        if (hi > lo + 1) return SampleW'($urandom_range(hi - 1, lo + 1));
        return SampleW'($urandom_range(4095, 0));
      end
      AX_HIGH: begin
        if (hi < 4095) return SampleW'($urandom_range(4095, hi + 1));
        return FULL;
      end
      AX_LOW: begin
        if (lo > 0) return SampleW'($urandom_range(lo - 1, 0));
        return ZERO;
      end
      AX_AT_HIGH: return cfg_high;
      AX_AT_LOW:  return cfg_low;
      default:    return SampleW'($urandom_range(4095, 0));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Predicts every tick that the block accepts.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      pending_events.push_back(decode_tick(button_level, x_sample, y_sample));
  end

  // Compares each result transaction with the oldest prediction.
  always @(posedge clk) begin
    tick_event_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        report_mismatch("result with nothing expected, action", int'(action), 0);
      end else begin
        want = pending_events.pop_front();
        if (action !== want.act)
          report_mismatch("action", int'(action), int'(want.act));
        if (read_done !== want.rd)
          report_mismatch("read_done", int'(read_done), int'(want.rd));
      end
    end
  end

  // Result side: random stalls, plus a long hold-off when one is requested.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end else if (gaps_enabled && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (pick_gap() + 1) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // Offers one tick and returns at the edge where it is accepted.
  task automatic send_tick(input logic btn, input logic [SampleW-1:0] x,
                           input logic [SampleW-1:0] y);
    int gap;
    gap = gaps_enabled ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    button_level <= btn;
    x_sample     <= x;
    y_sample     <= y;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering ticks and waits until every result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all four registers; only called while nothing is in flight.
  task automatic set_config(input logic [TimeW-1:0] interval, input logic [TimeW-1:0] long_ms,
                            input logic [SampleW-1:0] hi, input logic [SampleW-1:0] lo);
    cfg_we    <= 1'b1;
    cfg_index <= REG_READ_INTERVAL;
    cfg_data  <= interval;
    @(posedge clk);
    cfg_index <= REG_LONG_PRESS;
    cfg_data  <= long_ms;
    @(posedge clk);
    cfg_index <= REG_HIGH_THRESH;
    cfg_data  <= CfgDataW'(hi);
    @(posedge clk);
    cfg_index <= REG_LOW_THRESH;
    cfg_data  <= CfgDataW'(lo);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_read_interval = interval;
    cfg_long_press    = long_ms;
    cfg_high          = hi;
    cfg_low           = lo;
  endtask

  // Bursts of held buttons and stick excursions with random content, plus noise.
  task automatic run_gestures(input int count);
    int          left;
    bit          noise;
    logic        btn;
    axis_kind_t  kx;
    axis_kind_t  ky;
    left  = 0;
    noise = 1'b0;
    btn   = 1'b1;
    kx    = AX_CENTRE;
    ky    = AX_CENTRE;
    for (int i = 0; i < count; i++) begin
      if (left == 0) begin
        noise = ($urandom_range(0, 99) < 15);
        btn   = ($urandom_range(0, 2) != 0);
        kx    = pick_kind();
        ky    = pick_kind();
        left  = btn ? $urandom_range(1, 12) : $urandom_range(1, 40);
      end
      if (noise)
        send_tick(1'($urandom_range(0, 1)), SampleW'($urandom_range(0, 4095)),
                  SampleW'($urandom_range(0, 4095)));
      else
        send_tick(btn, axis_value(kx), axis_value(ky));
      left--;
    end
    drain();
  endtask

  // Ticks straight after reset, under the reset values of the registers.
  task automatic test_reset_config();
    run_gestures(60);
  endtask

  // Each direction, latching, re-arming, priority and samples equal to a threshold.
  task automatic test_directions();
    set_config(16'd0, 16'd2, HIGH_THRESH_RST, LOW_THRESH_RST);
    send_tick(1'b1, MID, MID);
    send_tick(1'b1, MID, FULL);
    send_tick(1'b1, MID, FULL);
    send_tick(1'b1, MID, HIGH_THRESH_RST);
    send_tick(1'b1, MID, ZERO);
    send_tick(1'b1, MID, MID);
    send_tick(1'b1, MID, ZERO);
    send_tick(1'b1, MID, MID);
    send_tick(1'b1, FULL, MID);
    send_tick(1'b1, MID, MID);
    send_tick(1'b1, ZERO, MID);
    send_tick(1'b1, MID, MID);
    send_tick(1'b1, ZERO, FULL);
    send_tick(1'b1, MID, MID);
    send_tick(1'b1, LOW_THRESH_RST, MID);
    send_tick(1'b1, MID, MID);
    drain();
  endtask

  // Click, long click, and button events replaced by a direction.
  task automatic test_button();
    repeat (4) send_tick(1'b0, MID, MID);
    send_tick(1'b1, MID, MID);
    repeat (2) send_tick(1'b0, MID, MID);
    send_tick(1'b1, MID, MID);
    send_tick(1'b0, MID, FULL);
    send_tick(1'b1, MID, FULL);
    send_tick(1'b1, MID, MID);
    repeat (3) send_tick(1'b0, MID, MID);
    send_tick(1'b0, ZERO, MID);
    send_tick(1'b1, MID, MID);
    drain();
  endtask

  // Largest interval and hold limit: no reads, then no long click.
  task automatic test_timer_extremes();
    set_config(TMAX, TMAX, HIGH_THRESH_RST, LOW_THRESH_RST);
    repeat (4) send_tick(1'b0, ZERO, FULL);
    drain();
    set_config(16'd0, TMAX, HIGH_THRESH_RST, LOW_THRESH_RST);
    repeat (6) send_tick(1'b0, MID, MID);
    send_tick(1'b1, MID, MID);
    drain();
  endtask

  // Thresholds at the ends of the range, crossed over each other, and next to each other.
  task automatic test_threshold_extremes();
    set_config(16'd0, 16'd5, FULL, ZERO);
    run_gestures(40);
    set_config(16'd1, 16'd0, ZERO, FULL);
    run_gestures(40);
    set_config(16'd0, 16'd3, 12'd2048, 12'd2047);
    run_gestures(40);
  endtask

  // The result side holds off long enough for the block to stall its input.
  task automatic test_backpressure();
    set_config(16'd0, 16'd4, HIGH_THRESH_RST, LOW_THRESH_RST);
    gaps_enabled   = 1'b0;
    rx_hold_cycles = 150;
    run_gestures(60);
    gaps_enabled = 1'b1;
  endtask

  // Random settings per phase, mostly short intervals so that reads are frequent.
  task automatic test_random_phases();
    logic [TimeW-1:0]   interval;
    logic [TimeW-1:0]   long_ms;
    logic [SampleW-1:0] hi;
    logic [SampleW-1:0] lo;
    int                 r;
    for (int p = 0; p < 14; p++) begin
      r = $urandom_range(0, 9);
      if (r < 4) interval = 16'd0;
      else if (r < 6) interval = 16'd1;
      else if (r < 8) interval = TimeW'($urandom_range(2, 4));
      else if (r < 9) interval = TimeW'($urandom_range(5, 20));
      else interval = TimeW'($urandom_range(0, 65535));
      r = $urandom_range(0, 9);
      if (r < 2) long_ms = 16'd0;
      else if (r < 7) long_ms = TimeW'($urandom_range(1, 12));
      else if (r < 9) long_ms = TimeW'($urandom_range(13, 60));
      else long_ms = TMAX;
      if ($urandom_range(0, 4) == 0) begin
        hi = SampleW'($urandom_range(0, 4095));
        lo = SampleW'($urandom_range(0, 4095));
      end else begin
        hi = SampleW'($urandom_range(2000, 4000));
        lo = SampleW'($urandom_range(100, 1999));
      end
      set_config(interval, long_ms, hi, lo);
      gaps_enabled = (p % 3 != 0);
      run_gestures(80);
    end
    gaps_enabled = 1'b1;
  endtask

  // Test sequence and final verdict.
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_config();
    test_directions();
    test_button();
    test_timer_extremes();
    test_threshold_extremes();
    test_backpressure();
    test_random_phases();
    drain();
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Run limit.
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
src/jed_pkg.sv
src/jed_step.sv
src/joystick_event_decoder_top.sv
tb/sv/tb.sv
